// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, opcodes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int OPC_W     = 3;
	localparam int WORD_W    = 64;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 8;
	localparam int OCC_W     = 9;

	typedef logic [OPC_W-1:0]  opc_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [OCC_W-1:0]  occ_t;

	localparam opc_t OP_PUSH_FRONT = 3'd0;
	localparam opc_t OP_PUSH_BACK  = 3'd1;
	localparam opc_t OP_POP_FRONT  = 3'd2;
	localparam opc_t OP_POP_BACK   = 3'd3;
	localparam opc_t OP_SEARCH     = 3'd4;

	localparam stat_t ST_OK        = 2'd0;
	localparam stat_t ST_FULL      = 2'd1;
	localparam stat_t ST_EMPTY     = 2'd2;
	localparam stat_t ST_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_RESULT
	} state_t;

	typedef struct packed {
		stat_t status;
		word_t data;
		pos_t  position;
		occ_t  occupancy;
	} res_t;

endpackage

// ===== sv/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int WIDTH = deq_pkg::WORD_W,
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Front index, entry count and sequencer: pushes, pops and the search scan
// over the word store.
// ----------------------------------------------------------------------------
module deq_ctrl #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int SW = AW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  deq_pkg::opc_t        opcode,
	input  deq_pkg::word_t       data_in,
	output logic                 res_valid,
	input  logic                 res_ready,
	output deq_pkg::res_t        res,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output deq_pkg::word_t       wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  deq_pkg::word_t       rd_data
);

	deq_pkg::state_t state_q, state_d;
	logic [AW-1:0]   front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   iss_q;
	logic            chk_vld_s1;
	logic [CW-1:0]   chk_off_s1;
	deq_pkg::word_t  key_q;
	deq_pkg::res_t   res_q, acc_res;

	logic acc, full, empty, hit, scan_done, issue;
	logic [AW-1:0] front_dec, front_inc;

	// ring slot at an offset from the front; the sum stays below twice DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return AW'(sum);
	endfunction

	assign acc       = item_valid && item_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign hit       = (rd_data == key_q);
	// stop once a compare hits, or every held word has been compared
	assign scan_done = (chk_vld_s1 && hit) || (!chk_vld_s1 && (iss_q == count_q));
	assign issue     = (state_q == deq_pkg::S_SCAN) && (iss_q != count_q) && !scan_done;
	assign res       = res_q;

	// result and pointer updates for the item being transferred in
	always_comb begin
		front_d           = front_q;
		count_d           = count_q;
		acc_res.status    = deq_pkg::ST_OK;
		acc_res.data      = '0;
		acc_res.position  = '0;
		acc_res.occupancy = deq_pkg::occ_t'(count_q);
		unique case (opcode) inside
			deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					acc_res.status = deq_pkg::ST_FULL;
				end else begin
					if (opcode == deq_pkg::OP_PUSH_FRONT) begin
						front_d = front_dec;
					end
					count_d           = count_q + CW'(1);
					acc_res.occupancy = deq_pkg::occ_t'(count_d);
				end
			end
			deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
				if (empty) begin
					acc_res.status = deq_pkg::ST_EMPTY;
				end else begin
					if (opcode == deq_pkg::OP_POP_FRONT) begin
						front_d = front_inc;
					end
					count_d           = count_q - CW'(1);
					acc_res.occupancy = deq_pkg::occ_t'(count_d);
				end
			end
			deq_pkg::OP_SEARCH: begin
				acc_res.status = deq_pkg::ST_NOT_FOUND;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				if (item_valid) begin
					unique case (opcode) inside
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
							state_d = empty ? deq_pkg::S_RESULT : deq_pkg::S_POP;
						deq_pkg::OP_SEARCH:
							state_d = empty ? deq_pkg::S_RESULT : deq_pkg::S_SCAN;
						default:
							state_d = deq_pkg::S_RESULT;
					endcase
				end
			end
			deq_pkg::S_POP: state_d = deq_pkg::S_RESULT;
			deq_pkg::S_SCAN: begin
				if (scan_done) begin
					state_d = deq_pkg::S_RESULT;
				end
			end
			deq_pkg::S_RESULT: begin
				if (res_ready) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: state_d = deq_pkg::S_IDLE;
		endcase
	end

	// outputs and store accesses
	always_comb begin
		item_ready = (state_q == deq_pkg::S_IDLE);
		res_valid  = (state_q == deq_pkg::S_RESULT);
		wr_en      = acc && !full &&
			((opcode == deq_pkg::OP_PUSH_FRONT) || (opcode == deq_pkg::OP_PUSH_BACK));
		wr_addr    = (opcode == deq_pkg::OP_PUSH_FRONT) ? front_dec : slot(front_q, count_q);
		wr_data    = data_in;
		rd_en      = 1'b0;
		rd_addr    = slot(front_q, iss_q);
		if (state_q == deq_pkg::S_SCAN) begin
			rd_en = issue;
		end else if (acc && !empty) begin
			rd_en   = (opcode == deq_pkg::OP_POP_FRONT) || (opcode == deq_pkg::OP_POP_BACK);
			rd_addr = (opcode == deq_pkg::OP_POP_FRONT) ? front_q :
				slot(front_q, count_q - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= deq_pkg::S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			iss_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= issue;
			if (acc) begin
				front_q <= front_d;
				count_q <= count_d;
				iss_q   <= '0;
			end else if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_off_s1 <= iss_q;
		if (acc) begin
			key_q <= data_in;
			res_q <= acc_res;
		end else if (state_q == deq_pkg::S_POP) begin
			res_q.data <= rd_data;
		end else if ((state_q == deq_pkg::S_SCAN) && chk_vld_s1 && hit) begin
			res_q.status   <= deq_pkg::ST_OK;
			res_q.position <= deq_pkg::pos_t'(chk_off_s1);
		end
	end

endmodule

// ===== sv/double_ended_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of 64-bit words in a ring buffer with a linear key search.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_ready     | opcode, data_in
//  result   | result_valid / result_ready | status, data_out, position,
//           |                             | occupancy
//
// Push, full or empty answers and unused opcodes: IDLE, then RESULT.
// Pop: IDLE, POP for the registered read of the word store, then RESULT.
// Search: IDLE, SCAN, then RESULT; the single read port of the word store
// is swept one entry a cycle from the front, each compare in the next cycle.
// Reset empties the queue at once; no clearing pass, the store is never read
// outside the held range. The result register lets the next item in while
// a result waits; a second finished result waits until the first is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  deq_pkg::opc_t       opcode,
	input  deq_pkg::word_t      data_in,
	output logic                result_valid,
	input  logic                result_ready,
	output deq_pkg::stat_t      status,
	output deq_pkg::word_t      data_out,
	output deq_pkg::pos_t       position,
	output deq_pkg::occ_t       occupancy
);

	logic           res_valid, res_ready;
	deq_pkg::res_t  res, out_q;
	logic           wr_en, rd_en;
	logic [AW-1:0]  wr_addr, rd_addr;
	deq_pkg::word_t wr_data, rd_data;

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.opcode     (opcode),
		.data_in    (data_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	deq_ram #(.WIDTH(deq_pkg::WORD_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// output register: free, or emptied by a transfer in the same cycle
	assign res_ready = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_ready) begin
			result_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign status    = out_q.status;
	assign data_out  = out_q.data;
	assign position  = out_q.position;
	assign occupancy = out_q.occupancy;

endmodule

// ===== sv/deq_chk.sv =====
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks on the result channel of the deque, bound to the top.
// ----------------------------------------------------------------------------
module deq_chk #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           result_valid,
	input logic           result_ready,
	input deq_pkg::stat_t status,
	input deq_pkg::word_t data_out,
	input deq_pkg::pos_t  position,
	input deq_pkg::occ_t  occupancy
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) &&
		$stable(data_out) && $stable(position) && $stable(occupancy))
		else $error("stalled result changed");

	// only a successful pop returns a word
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != deq_pkg::ST_OK) |-> data_out == '0)
		else $error("data_out set on a failed operation");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == deq_pkg::ST_EMPTY) |-> occupancy == '0)
		else $error("empty reported with words held");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == deq_pkg::ST_FULL) |-> occupancy == deq_pkg::occ_t'(DEPTH))
		else $error("full reported below capacity");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == deq_pkg::ST_NOT_FOUND) |-> position == '0)
		else $error("position set on a failed search");

endmodule

bind double_ended_queue_with_search deq_chk #(.DEPTH(DEPTH)) u_deq_chk (.*);
